// ===== hdl/ssip_pkg.sv =====
// ssip_pkg: request/response payload types, request kinds, status codes and
// the control struct that drives the row of cells.
// No dependencies.
package ssip_pkg;

    localparam int KEY_FIELD_W = 32;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_UNIQUE = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [KEY_FIELD_W-1:0] key_value;
    } ssip_req_t;

    typedef struct packed {
        logic [2:0]                    status;
        logic signed [KEY_FIELD_W-1:0] result_key;
        logic [POS_W-1:0]              position;
        logic [COUNT_W-1:0]            entry_count;
    } ssip_rsp_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } ssip_cell_ctl_t;

endpackage

// ===== hdl/ssip_cell.sv =====
// ssip_cell: one slot of the sorted row; holds a key and its occupancy bit,
// compares against the broadcast key and shifts with its neighbors.
// Depends on ssip_pkg.
module ssip_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ssip_pkg::ssip_cell_ctl_t   ctl,
    input  logic                       head,
    input  logic signed [KEY_BITS-1:0] key,
    input  logic signed [KEY_BITS-1:0] left_entry,
    input  logic                       left_occ,
    input  logic                       left_ahead,
    input  logic                       left_eq,
    input  logic signed [KEY_BITS-1:0] right_entry,
    input  logic                       right_occ,
    output logic signed [KEY_BITS-1:0] entry,
    output logic                       occ,
    output logic                       ahead,
    output logic                       eq,
    output logic                       first_eq,
    output logic                       take
);

    logic signed [KEY_BITS-1:0] entry_reg, entry_next;
    logic                       occ_reg, occ_next;
    logic                       less;

    assign less     = occ_reg && (entry_reg < key);
    assign eq       = occ_reg && (entry_reg == key);
    assign ahead    = less || (head && eq);
    assign take     = !ahead && left_ahead;
    assign first_eq = eq && !left_eq;
    assign entry    = entry_reg;
    assign occ      = occ_reg;

    always_comb begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        priority if (ctl.insert) begin
            if (!ahead) begin
                entry_next = left_ahead ? key : left_entry;
                occ_next   = left_occ;
            end
        end else if (ctl.pop) begin
            entry_next = right_entry;
            occ_next   = right_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    a_row_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg && right_occ) |-> (entry_reg <= right_entry))
        else $error("cell row out of order");

endmodule

// ===== hdl/ssip_result.sv =====
// ssip_result: holding stage and output register of the response path;
// encodes the one-hot slot select into the reported position.
// Depends on ssip_pkg.
module ssip_result #(
    parameter int CAPACITY = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_load,
    input  ssip_pkg::ssip_rsp_t   in_rsp,
    input  logic [CAPACITY-1:0]   in_sel,
    output logic                  in_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ssip_pkg::ssip_rsp_t   m_rsp
);

    logic                        st1_valid_reg;
    ssip_pkg::ssip_rsp_t         st1_rsp_reg;
    logic [CAPACITY-1:0]         st1_sel_reg;
    logic                        m_valid_reg;
    ssip_pkg::ssip_rsp_t         m_rsp_reg;
    ssip_pkg::ssip_rsp_t         out_rsp;
    logic [ssip_pkg::POS_W-1:0]  pos;
    logic                        advance;

    assign advance  = !m_valid_reg || m_ready;
    assign in_ready = !st1_valid_reg || advance;
    assign m_valid  = m_valid_reg;
    assign m_rsp    = m_rsp_reg;

    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (st1_sel_reg[i]) begin
                pos = pos | ssip_pkg::POS_W'(i);
            end
        end
        out_rsp          = st1_rsp_reg;
        out_rsp.position = pos;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                st1_valid_reg <= in_load;
            end
            if (advance) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            st1_rsp_reg <= in_rsp;
            st1_sel_reg <= in_sel;
        end
        if (advance && st1_valid_reg) begin
            m_rsp_reg <= out_rsp;
        end
    end

endmodule

// ===== hdl/sorted_set_insert_pop.sv =====
// sorted_set_insert_pop: bounded sorted key store built as a row of shifting
// cells, with insert, insert-unique, pop-smallest and search requests.
// Depends on ssip_pkg, ssip_cell, ssip_result.
//
//  port group      | dir | handshake        | payload
//  s_ (request)    | in  | s_valid/s_ready  | s_req : ssip_req_t (kind, key_value)
//  m_ (response)   | out | m_valid/m_ready  | m_rsp : ssip_rsp_t (status, result_key,
//                  |     |                  |         position, entry_count)
//
// One request per cycle sustained while m_ready is high; the response goes
// through the holding stage, the position encoder and the output register to
// m_. All cells compare against the key in parallel and shift in the accept cycle.
// Reset (aresetn low, synchronous) clears occupancy and count; no clearing pass.
// With m_ready low the response holds, one more request waits in the middle
// stage, then s_ready drops.
module sorted_set_insert_pop #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ssip_pkg::ssip_req_t  s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ssip_pkg::ssip_rsp_t  m_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [KEY_BITS-1:0]  key_in, rkey;
    logic signed [KEY_BITS-1:0]  ent_w [CAPACITY+2];
    logic [CAPACITY+1:0]         occ_w;
    logic [CAPACITY:0]           ahead_w;
    logic [CAPACITY:0]           eq_w;
    logic [CAPACITY-1:0]         occ, feq, take, sel;
    logic                        acc, full, empty, hit;
    logic [2:0]                  status;
    ssip_pkg::ssip_cell_ctl_t    ctl;
    ssip_pkg::ssip_rsp_t         rsp;

    assign key_in = KEY_BITS'(s_req.key_value);
    assign acc    = s_valid && s_ready;

    assign ent_w[0]           = key_in;
    assign ent_w[CAPACITY+1]  = '0;
    assign occ_w[0]           = 1'b1;
    assign occ_w[CAPACITY+1]  = 1'b0;
    assign ahead_w[0]         = 1'b1;
    assign eq_w[0]            = 1'b0;
    assign occ                = occ_w[CAPACITY:1];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ssip_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .head        (i == 0),
            .key         (key_in),
            .left_entry  (ent_w[i]),
            .left_occ    (occ_w[i]),
            .left_ahead  (ahead_w[i]),
            .left_eq     (eq_w[i]),
            .right_entry (ent_w[i+2]),
            .right_occ   (occ_w[i+2]),
            .entry       (ent_w[i+1]),
            .occ         (occ_w[i+1]),
            .ahead       (ahead_w[i+1]),
            .eq          (eq_w[i+1]),
            .first_eq    (feq[i]),
            .take        (take[i])
        );
    end

    assign full  = occ[CAPACITY-1];
    assign empty = !occ[0];
    assign hit   = |feq;

    always_comb begin
        ctl        = '0;
        status     = ssip_pkg::ST_INSERTED;
        rkey       = key_in;
        sel        = '0;
        count_next = count_reg;
        unique case (s_req.kind)
            ssip_pkg::KIND_INSERT, ssip_pkg::KIND_UNIQUE: begin
                if (s_req.kind == ssip_pkg::KIND_UNIQUE && hit) begin
                    status = ssip_pkg::ST_FOUND;
                    sel    = feq;
                end else if (full) begin
                    status = ssip_pkg::ST_FULL;
                end else begin
                    ctl.insert = acc;
                    sel        = take;
                    count_next = count_reg + 1'b1;
                end
            end
            ssip_pkg::KIND_POP: begin
                if (empty) begin
                    status = ssip_pkg::ST_EMPTY;
                    rkey   = '0;
                end else begin
                    ctl.pop    = acc;
                    rkey       = ent_w[1];
                    count_next = count_reg - 1'b1;
                end
            end
            ssip_pkg::KIND_SEARCH: begin
                if (hit) begin
                    status = ssip_pkg::ST_FOUND;
                    sel    = feq;
                end else begin
                    status = ssip_pkg::ST_MISSING;
                end
            end
            default: begin
                status = ssip_pkg::ST_MISSING;
            end
        endcase
    end

    assign rsp = '{
        status:      status,
        result_key:  ssip_pkg::KEY_FIELD_W'(rkey),
        position:    '0,
        entry_count: ssip_pkg::COUNT_W'(count_next)
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (acc) begin
            count_reg <= count_next;
        end
    end

    ssip_result #(
        .CAPACITY (CAPACITY)
    ) u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_load  (acc),
        .in_rsp   (rsp),
        .in_sel   (sel),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rsp    (m_rsp)
    );

    a_count_matches_row: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(occ)))
        else $error("count disagrees with cell occupancy");

    a_occ_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot({1'b0, occ} + 1'b1))
        else $error("occupied cells not contiguous from the head");

    a_sel_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> $onehot0(sel))
        else $error("more than one slot selected for position");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_req.kind == ssip_pkg::KIND_POP && !empty)
            |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not shrink the store");

endmodule
